FILE: hw/rtl/bdq_pkg.sv
// Package for the bounded double-ended queue core.
// Holds widths, command and status codes, and the controller/datapath structs.
// Depends on nothing; used by every module of the core except bdq_ram.
package bdq_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 3;
	localparam int CAP_W     = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_BACK  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_PUSH_FRONT = 3'd0,
		ST_PUSH_BACK  = 3'd1,
		ST_POP_FRONT  = 3'd2,
		ST_POP_BACK   = 3'd3,
		ST_FULL       = 3'd4,
		ST_EMPTY      = 3'd5
	} status_t;

	typedef struct packed {
		logic load_cmd;
		logic exec;
		logic capture_rd;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_read;
	} dp_stat_t;

endpackage

FILE: hw/rtl/bdq_ram.sv
// Generic single-port RAM with registered read data.
// Used for the entry store of the queue; depends on no package.
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bdq_ctrl.sv
// Controller state machine of the queue core.
// Sequences accept, execute, read and output load; uses bdq_pkg.
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  bdq_pkg::dp_stat_t dp_stat,
	output bdq_pkg::dp_cmd_t  dp_cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.load_cmd   = (state_q == S_IDLE) && in_valid;
		dp_cmd.exec       = (state_q == S_EXEC);
		dp_cmd.capture_rd = (state_q == S_READ);
		dp_cmd.load_out   = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= dp_stat.need_read ? S_READ : S_DONE;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/bdq_dp.sv
// Datapath of the queue core: pointers, occupancy, capacity register,
// entry store and result registers. Uses bdq_pkg and bdq_ram.
module bdq_dp #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [bdq_pkg::CMD_W-1:0]         command,
	input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
	input  logic                              cfg_wr_en,
	input  logic [bdq_pkg::CAP_W-1:0]         cfg_wr_data,
	input  bdq_pkg::dp_cmd_t                  dp_cmd,
	output bdq_pkg::dp_stat_t                 dp_stat,
	output logic [bdq_pkg::STAT_W-1:0]        status,
	output logic signed [bdq_pkg::DATA_W-1:0] result_value
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int SUM_W = $clog2(2 * DEPTH);
	localparam int LIM_W = (OCC_W > bdq_pkg::CAP_W) ? OCC_W : bdq_pkg::CAP_W;

	bdq_pkg::cmd_t              cmd_q;
	logic [bdq_pkg::DATA_W-1:0] val_q;
	logic [PTR_W-1:0]           front_q;
	logic [OCC_W-1:0]           occ_q;
	logic [bdq_pkg::CAP_W-1:0]  cap_q;
	bdq_pkg::status_t           res_status_q;
	logic [bdq_pkg::DATA_W-1:0] res_value_q;
	logic [bdq_pkg::STAT_W-1:0] out_status_q;
	logic [bdq_pkg::DATA_W-1:0] out_value_q;

	logic [LIM_W-1:0]           cap_ext;
	logic [LIM_W-1:0]           limit;
	logic                       is_push;
	logic                       full;
	logic                       empty;
	logic [PTR_W-1:0]           front_dec;
	logic [PTR_W-1:0]           front_inc;
	logic [PTR_W-1:0]           back_idx;
	logic [PTR_W-1:0]           back_last;
	logic [PTR_W-1:0]           ram_addr;
	logic                       ram_we;
	logic [bdq_pkg::DATA_W-1:0] ram_rdata;

	function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
		return r[PTR_W-1:0];
	endfunction

	assign cap_ext   = LIM_W'(cap_q);
	assign limit     = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
	assign is_push   = (cmd_q == bdq_pkg::CMD_PUSH_FRONT) || (cmd_q == bdq_pkg::CMD_PUSH_BACK);
	assign full      = LIM_W'(occ_q) >= limit;
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign back_idx  = wrap_idx(SUM_W'(front_q) + SUM_W'(occ_q));
	assign back_last = wrap_idx(SUM_W'(front_q) + SUM_W'(occ_q) - SUM_W'(1));

	always_comb begin
		unique case (cmd_q)
			bdq_pkg::CMD_PUSH_FRONT: ram_addr = front_dec;
			bdq_pkg::CMD_PUSH_BACK:  ram_addr = back_idx;
			bdq_pkg::CMD_POP_FRONT:  ram_addr = front_q;
			bdq_pkg::CMD_POP_BACK:   ram_addr = back_last;
			default:                 ram_addr = front_q;
		endcase
	end

	assign ram_we            = dp_cmd.exec && is_push && !full;
	assign dp_stat.need_read = !is_push && !empty;

	bdq_ram #(
		.WIDTH(bdq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(val_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
			cap_q   <= bdq_pkg::CAP_RESET;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (dp_cmd.exec) begin
				unique case (cmd_q)
					bdq_pkg::CMD_PUSH_FRONT: begin
						if (!full) begin
							front_q <= front_dec;
							occ_q   <= occ_q + 1'b1;
						end
					end
					bdq_pkg::CMD_PUSH_BACK: begin
						if (!full) begin
							occ_q <= occ_q + 1'b1;
						end
					end
					bdq_pkg::CMD_POP_FRONT: begin
						if (!empty) begin
							front_q <= front_inc;
							occ_q   <= occ_q - 1'b1;
						end
					end
					bdq_pkg::CMD_POP_BACK: begin
						if (!empty) begin
							occ_q <= occ_q - 1'b1;
						end
					end
					default: begin
						occ_q <= occ_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load_cmd) begin
			cmd_q <= bdq_pkg::cmd_t'(command);
			val_q <= $unsigned(push_value);
		end
		if (dp_cmd.exec) begin
			res_value_q <= '0;
			if (is_push) begin
				if (full) begin
					res_status_q <= bdq_pkg::ST_FULL;
				end else begin
					res_value_q  <= val_q;
					res_status_q <= (cmd_q == bdq_pkg::CMD_PUSH_FRONT) ?
						bdq_pkg::ST_PUSH_FRONT : bdq_pkg::ST_PUSH_BACK;
				end
			end else begin
				if (empty) begin
					res_status_q <= bdq_pkg::ST_EMPTY;
				end else begin
					res_status_q <= (cmd_q == bdq_pkg::CMD_POP_FRONT) ?
						bdq_pkg::ST_POP_FRONT : bdq_pkg::ST_POP_BACK;
				end
			end
		end
		if (dp_cmd.capture_rd) begin
			res_value_q <= ram_rdata;
		end
		if (dp_cmd.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
	end

	assign status       = out_status_q;
	assign result_value = $signed(out_value_q);

endmodule

FILE: hw/rtl/bounded_double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// Joins the controller (bdq_ctrl) and the datapath (bdq_dp); uses bdq_pkg.
//
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_stall   command, push_value
// output    out        out_valid / out_stall status, result_value
// config    in         cfg_wr_en             cfg_wr_data (capacity)
//
// A push or refused command runs the execute and done states before the next acceptance.
// A successful pop adds a read state between them, for the registered read of the store.
// The result sits in an output register, so the next word is taken while it waits.
// A stall on the output holds the controller only when a new result is ready to load.
// Reset clears the pointers and occupancy and sets capacity to 16; the store is not cleared.
module bounded_double_ended_queue_core #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bdq_pkg::CMD_W-1:0]         command,
	input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bdq_pkg::STAT_W-1:0]        status,
	output logic signed [bdq_pkg::DATA_W-1:0] result_value,
	input  logic                              cfg_wr_en,
	input  logic [bdq_pkg::CAP_W-1:0]         cfg_wr_data
);

	bdq_pkg::dp_cmd_t  dp_cmd;
	bdq_pkg::dp_stat_t dp_stat;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dp_stat  (dp_stat),
		.dp_cmd   (dp_cmd)
	);

	bdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.push_value  (push_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.status      (status),
		.result_value(result_value)
	);

`ifndef SYNTHESIS
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |=> out_valid)
		else $error("output load did not raise out_valid");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({dp_cmd.load_cmd, dp_cmd.exec, dp_cmd.capture_rd, dp_cmd.load_out}))
		else $error("more than one datapath command active");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bdq_pkg::ST_FULL || status == bdq_pkg::ST_EMPTY)
		|-> result_value == '0)
		else $error("refused command carries a nonzero value");
`endif

endmodule
